// ===== hdl/mlfr_pkg.sv =====
package mlfr_pkg;

	localparam int DEF_BUFFER_BYTES = 512;

	// frame framing bytes
	localparam logic [7:0] START_BYTE = 8'h68;
	localparam logic [7:0] STOP_BYTE  = 8'h16;
	localparam logic [7:0] CI_BYTE    = 8'h72;

	// first offset searched for data records
	localparam logic [8:0] REC_FIRST_OFS = 9'd19;

	// status codes
	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_INCOMPLETE = 3'd1;
	localparam logic [2:0] ST_MALFORMED  = 3'd2;
	localparam logic [2:0] ST_BAD_STOP   = 3'd3;
	localparam logic [2:0] ST_CHECKSUM   = 3'd4;
	localparam logic [2:0] ST_BAD_CI     = 3'd5;
	localparam logic [2:0] ST_SHORT_HDR  = 3'd6;

	// record kinds
	localparam logic [3:0] K_SERIAL  = 4'd0;
	localparam logic [3:0] K_MANUF   = 4'd1;
	localparam logic [3:0] K_VERSION = 4'd2;
	localparam logic [3:0] K_ERRCODE = 4'd4;
	localparam logic [3:0] K_ERRSTRT = 4'd5;
	localparam logic [3:0] K_LAST    = 4'd14;
	localparam logic [3:0] K_REC0    = 4'd3;

	localparam int NUM_REC = 12;

	// searched record pattern: plen3 selects three bytes, wide selects a 4-byte value
	typedef struct packed {
		logic       plen3;
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
		logic       wide;
	} rec_pat_t;

	localparam rec_pat_t REC_PAT [NUM_REC] = '{
		'{1'b0, 8'h04, 8'h6D, 8'h00, 1'b1},  // datetime
		'{1'b1, 8'h34, 8'hFD, 8'h17, 1'b1},  // error code
		'{1'b0, 8'h34, 8'h6D, 8'h00, 1'b1},  // error start
		'{1'b0, 8'h04, 8'h20, 8'h00, 1'b1},
		'{1'b0, 8'h04, 8'h24, 8'h00, 1'b1},
		'{1'b1, 8'h04, 8'h86, 8'h3B, 1'b1},
		'{1'b0, 8'h04, 8'h13, 8'h00, 1'b1},
		'{1'b0, 8'h04, 8'h2B, 8'h00, 1'b1},
		'{1'b0, 8'h04, 8'h3B, 8'h00, 1'b1},
		'{1'b0, 8'h02, 8'h59, 8'h00, 1'b0},
		'{1'b0, 8'h02, 8'h5D, 8'h00, 1'b0},
		'{1'b0, 8'h02, 8'h61, 8'h00, 1'b0}
	};

	localparam int REC_EC = 1;
	localparam int REC_ES = 2;

endpackage

// ===== hdl/mlfr_mem.sv =====
module mlfr_mem #(
	parameter int DEPTH = 512,
	parameter int AW    = 9
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [7:0]    wr_data,
	input  logic [AW-1:0] rd_addr,
	output logic [7:0]    rd_data
);

	logic [7:0] mem [DEPTH];
	logic [7:0] rd_data_q;

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

// ===== hdl/mbus_long_frame_receiver.sv =====
// Each item is one byte; the block scans the buffered bytes and checks the frame at every
// 0x68 start tried, reading the bytes through the single read port of the byte memory,
// then decodes a valid frame.
// Throughput: one item at a time; the next item is taken once the last result of the
// previous one has been loaded into the output register.
// Reset (arst_n low) empties the buffer at once; no clearing pass is needed.
module mbus_long_frame_receiver #(
	parameter int BUFFER_BYTES = mlfr_pkg::DEF_BUFFER_BYTES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [3:0]  record_kind,
	output logic [31:0] record_value,
	output logic        no_error_mark,
	output logic        last_result
);
	import mlfr_pkg::*;

	localparam int AW = $clog2(BUFFER_BYTES);
	localparam int CW = $clog2(BUFFER_BYTES + 1);
	localparam int XW = ((CW > 9) ? CW : 9) + 1;
	localparam logic [XW:0] NBUF = (XW + 1)'(BUFFER_BYTES);

	typedef enum logic [3:0] {
		S_IDLE, S_SCAN_RD, S_SCAN_CHK, S_L1, S_L2, S_L3, S_STOP, S_SUM,
		S_CMP, S_CI, S_RSCAN, S_NEXTK, S_VAL, S_EMIT, S_FLUSH
	} state_t;

	state_t         state_q;
	logic [AW-1:0]  head_q;
	logic [CW-1:0]  fill_q, i_q, keep_q;
	logic [2:0]     err_q;
	logic [7:0]     len_q, sum_q, w1_q, w2_q;
	logic           mism_q;
	logic [8:0]     off_q, q_q, pos_q;
	logic [3:0]     kind_q;
	logic [1:0]     k_q, n_q;
	logic [31:0]    val_q;
	logic           mark_q, code_nz_q;
	logic [NUM_REC-1:0] seen_q, fit_q;
	logic [8:0]     rpos_q [NUM_REC];

	logic           pend_v_q;
	logic [2:0]     pend_st_q;
	logic [3:0]     pend_kind_q;
	logic [31:0]    pend_val_q;
	logic           pend_mark_q;

	logic           out_valid_q;
	logic [2:0]     out_st_q;
	logic [3:0]     out_kind_q;
	logic [31:0]    out_val_q;
	logic           out_mark_q, out_last_q;

	logic [XW-1:0]  rd_log;
	logic [AW-1:0]  rd_addr, wr_addr;
	logic [7:0]     rd_data;
	logic           wr_en, out_free, out_load;
	logic           fail_v;
	logic [2:0]     fail_st;
	logic [CW-1:0]  avail;
	logic [XW-1:0]  total;
	logic [8:0]     rec_end;
	logic [NUM_REC-1:0] hit;
	logic           nk_read, nk_zero;
	logic [8:0]     nk_pos;
	logic [1:0]     nk_n;

	// logical buffer position to memory address (circular)
	function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
		input logic [XW-1:0] lpos);
		logic [XW:0] s;
		s = (XW + 1)'(head) + (XW + 1)'(lpos);
		if (s >= NBUF) begin
			s = s - NBUF;
		end
		return s[AW-1:0];
	endfunction

	mlfr_mem #(.DEPTH(BUFFER_BYTES), .AW(AW)) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (rx_byte),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign in_stall = (state_q != S_IDLE);
	assign wr_en    = in_valid && (state_q == S_IDLE);
	assign wr_addr  = phys(head_q, XW'(fill_q));
	assign rd_addr  = phys(head_q, rd_log);
	assign out_free = !out_valid_q || !out_stall;
	assign out_load = out_free && ((state_q == S_FLUSH) || (state_q == S_EMIT && pend_v_q));
	assign avail    = fill_q - i_q;
	assign total    = XW'(len_q) + XW'(6);
	assign rec_end  = 9'(len_q) + 9'd4;

	// pattern hits at the current scan byte
	always_comb begin
		for (int r = 0; r < NUM_REC; r++) begin
			if (REC_PAT[r].plen3) begin
				hit[r] = (w2_q == REC_PAT[r].b0) && (w1_q == REC_PAT[r].b1) &&
					(rd_data == REC_PAT[r].b2) && (q_q >= REC_FIRST_OFS + 9'd2);
			end else begin
				hit[r] = (w1_q == REC_PAT[r].b0) && (rd_data == REC_PAT[r].b1) &&
					(q_q >= REC_FIRST_OFS + 9'd1);
			end
		end
	end

	// what the next emitted kind needs
	always_comb begin
		nk_read = 1'b0;
		nk_zero = 1'b0;
		nk_pos  = '0;
		nk_n    = 2'd3;
		if (kind_q == K_SERIAL) begin
			nk_read = 1'b1;
			nk_pos  = 9'd7;
		end else if (kind_q == K_MANUF) begin
			nk_read = 1'b1;
			nk_pos  = 9'd11;
			nk_n    = 2'd1;
		end else if (kind_q == K_VERSION) begin
			nk_read = 1'b1;
			nk_pos  = 9'd13;
			nk_n    = 2'd0;
		end else if (kind_q == K_ERRSTRT) begin
			if (fit_q[REC_EC]) begin
				nk_zero = !code_nz_q;
				nk_read = code_nz_q && fit_q[REC_ES];
			end
			nk_pos = rpos_q[REC_ES];
		end else if (kind_q <= K_LAST) begin
			for (int r = 0; r < NUM_REC; r++) begin
				if (kind_q == K_REC0 + 4'(r)) begin
					nk_read = fit_q[r];
					nk_pos  = rpos_q[r];
					nk_n    = REC_PAT[r].wide ? 2'd3 : 2'd1;
				end
			end
		end
	end

	// read address and frame check failures
	always_comb begin
		rd_log  = '0;
		fail_v  = 1'b0;
		fail_st = ST_INCOMPLETE;
		unique case (state_q)
			S_SCAN_RD:  rd_log = XW'(i_q);
			S_SCAN_CHK: begin
				rd_log = XW'(i_q) + XW'(1);
				if (rd_data == START_BYTE && avail < CW'(4)) begin
					fail_v = 1'b1;
				end
			end
			S_L1: rd_log = XW'(i_q) + XW'(2);
			S_L2: rd_log = XW'(i_q) + XW'(3);
			S_L3: begin
				rd_log = XW'(i_q) + XW'(len_q) + XW'(5);
				if (mism_q || rd_data != START_BYTE) begin
					fail_v  = 1'b1;
					fail_st = ST_MALFORMED;
				end else if (XW'(avail) < total) begin
					fail_v = 1'b1;
				end
			end
			S_STOP: begin
				rd_log = XW'(i_q) + XW'(4);
				if (rd_data != STOP_BYTE) begin
					fail_v  = 1'b1;
					fail_st = ST_BAD_STOP;
				end
			end
			S_SUM: rd_log = XW'(i_q) + XW'(off_q) + XW'(1);
			S_CMP: begin
				rd_log = XW'(i_q) + XW'(6);
				if (rd_data != sum_q) begin
					fail_v  = 1'b1;
					fail_st = ST_CHECKSUM;
				end else if (len_q < 8'd3) begin
					fail_v  = 1'b1;
					fail_st = ST_SHORT_HDR;
				end
			end
			S_CI: begin
				rd_log = XW'(i_q) + XW'(REC_FIRST_OFS);
				if (rd_data != CI_BYTE) begin
					fail_v  = 1'b1;
					fail_st = ST_BAD_CI;
				end else if (len_q < 8'd15) begin
					fail_v  = 1'b1;
					fail_st = ST_SHORT_HDR;
				end
			end
			S_RSCAN:  rd_log = XW'(i_q) + XW'(q_q) + XW'(1);
			S_NEXTK:  rd_log = XW'(i_q) + XW'(nk_pos);
			S_VAL:    rd_log = XW'(i_q) + XW'(pos_q) + XW'(k_q) + XW'(1);
			default:  rd_log = '0;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			fill_q      <= '0;
			pend_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && !out_load) begin
				out_valid_q <= 1'b0;
			end
			if (fail_v) begin
				if (fail_st == ST_INCOMPLETE) begin
					if (i_q < keep_q) begin
						keep_q <= i_q;
					end
				end else begin
					err_q <= fail_st;
				end
				i_q     <= i_q + CW'(1);
				state_q <= S_SCAN_RD;
			end else begin
				unique case (state_q)
					S_IDLE: begin
						if (in_valid) begin
							if (fill_q == CW'(BUFFER_BYTES)) begin
								head_q <= phys(head_q, XW'(1));
								keep_q <= fill_q;
							end else begin
								fill_q <= fill_q + CW'(1);
								keep_q <= fill_q + CW'(1);
							end
							i_q     <= '0;
							err_q   <= ST_INCOMPLETE;
							state_q <= S_SCAN_RD;
						end
					end
					S_SCAN_RD: begin
						if (i_q == fill_q) begin
							// no frame: trim to the earliest incomplete start
							head_q      <= phys(head_q, XW'(keep_q));
							fill_q      <= fill_q - keep_q;
							pend_st_q   <= err_q;
							pend_kind_q <= K_SERIAL;
							pend_val_q  <= '0;
							pend_mark_q <= 1'b0;
							pend_v_q    <= 1'b1;
							state_q     <= S_FLUSH;
						end else begin
							state_q <= S_SCAN_CHK;
						end
					end
					S_SCAN_CHK: begin
						if (rd_data == START_BYTE) begin
							state_q <= S_L1;
						end else begin
							i_q     <= i_q + CW'(1);
							state_q <= S_SCAN_RD;
						end
					end
					S_L1: begin
						len_q   <= rd_data;
						state_q <= S_L2;
					end
					S_L2: begin
						mism_q  <= (rd_data != len_q);
						state_q <= S_L3;
					end
					S_L3: state_q <= S_STOP;
					S_STOP: begin
						sum_q   <= '0;
						off_q   <= 9'd4;
						state_q <= (len_q == 8'd0) ? S_CMP : S_SUM;
					end
					S_SUM: begin
						sum_q <= sum_q + rd_data;
						off_q <= off_q + 9'd1;
						if (off_q == 9'(len_q) + 9'd3) begin
							state_q <= S_CMP;
						end
					end
					S_CMP: state_q <= S_CI;
					S_CI: begin
						// valid frame at i_q
						seen_q    <= '0;
						fit_q     <= '0;
						kind_q    <= K_SERIAL;
						mark_q    <= 1'b0;
						code_nz_q <= 1'b0;
						q_q       <= REC_FIRST_OFS;
						state_q   <= (len_q == 8'd15) ? S_NEXTK : S_RSCAN;
					end
					S_RSCAN: begin
						for (int r = 0; r < NUM_REC; r++) begin
							if (hit[r] && !seen_q[r]) begin
								seen_q[r] <= 1'b1;
								fit_q[r]  <= (10'(q_q) + 10'd1 +
									(REC_PAT[r].wide ? 10'd4 : 10'd2)) <= 10'(rec_end);
								rpos_q[r] <= q_q + 9'd1;
							end
						end
						w2_q <= w1_q;
						w1_q <= rd_data;
						if (q_q == rec_end - 9'd1) begin
							state_q <= S_NEXTK;
						end else begin
							q_q <= q_q + 9'd1;
						end
					end
					S_NEXTK: begin
						val_q <= '0;
						k_q   <= '0;
						pos_q <= nk_pos;
						n_q   <= nk_n;
						if (kind_q > K_LAST) begin
							fill_q  <= '0;
							state_q <= S_FLUSH;
						end else if (nk_read) begin
							state_q <= S_VAL;
						end else if (nk_zero) begin
							mark_q  <= 1'b1;
							state_q <= S_EMIT;
						end else begin
							kind_q <= kind_q + 4'd1;
						end
					end
					S_VAL: begin
						val_q <= val_q | (32'(rd_data) << {k_q, 3'b000});
						if (k_q == n_q) begin
							state_q <= S_EMIT;
						end else begin
							k_q <= k_q + 2'd1;
						end
					end
					S_EMIT: begin
						if (!pend_v_q || out_free) begin
							if (pend_v_q) begin
								out_valid_q <= 1'b1;
								out_st_q    <= pend_st_q;
								out_kind_q  <= pend_kind_q;
								out_val_q   <= pend_val_q;
								out_mark_q  <= pend_mark_q;
								out_last_q  <= 1'b0;
							end
							pend_v_q    <= 1'b1;
							pend_st_q   <= ST_OK;
							pend_kind_q <= kind_q;
							pend_val_q  <= val_q;
							pend_mark_q <= mark_q;
							if (kind_q == K_ERRCODE) begin
								code_nz_q <= (val_q != '0);
							end
							mark_q  <= 1'b0;
							kind_q  <= kind_q + 4'd1;
							state_q <= S_NEXTK;
						end
					end
					S_FLUSH: begin
						if (out_free) begin
							out_valid_q <= 1'b1;
							out_st_q    <= pend_st_q;
							out_kind_q  <= pend_kind_q;
							out_val_q   <= pend_val_q;
							out_mark_q  <= pend_mark_q;
							out_last_q  <= 1'b1;
							pend_v_q    <= 1'b0;
							state_q     <= S_IDLE;
						end
					end
					default: state_q <= S_IDLE;
				endcase
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = out_st_q;
	assign record_kind   = out_kind_q;
	assign record_value  = out_val_q;
	assign no_error_mark = out_mark_q;
	assign last_result   = out_last_q;

	// buffer bookkeeping stays in range
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q <= CW'(BUFFER_BYTES)) && (head_q < AW'(BUFFER_BYTES - 1) ||
		head_q == AW'(BUFFER_BYTES - 1)))
		else $error("buffer pointer out of range");

	// nothing left pending once idle
	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !pend_v_q)
		else $error("pending result left behind");

	// the last result of an item leaves the block idle
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FLUSH && out_free) |=> (state_q == S_IDLE && out_valid_q && out_last_q))
		else $error("flush did not finish item");

endmodule

// ===== test/mlfr_checker.sv =====
// Watches both channels, tracks the receive buffer and compares every result item.
module mlfr_checker #(
	parameter int BUF_BYTES = mlfr_pkg::DEF_BUFFER_BYTES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  rx_byte,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [2:0]  status,
	input  logic [3:0]  record_kind,
	input  logic [31:0] record_value,
	input  logic        no_error_mark,
	input  logic        last_result,
	output int          fail_count,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import mlfr_pkg::*;

	typedef struct {
		logic [2:0]  st;
		logic [3:0]  kind;
		logic [31:0] value;
		logic        mark;
		logic        last;
	} rec_item_t;

	rec_item_t   rec_q[$];
	logic [7:0]  rx_buf[BUF_BYTES];
	int unsigned rx_fill;

	assign pending = rec_q.size();

	function automatic logic [31:0] read_le(int unsigned pos, int unsigned n);
		logic [31:0] v;
		v = '0;
		for (int unsigned k = 0; k < n; k++)
			v |= 32'(rx_buf[pos + k]) << (8 * k);
		return v;
	endfunction

	function automatic void push_rec(logic [2:0] st, logic [3:0] kind, logic [31:0] value,
			logic mark);
		rec_item_t r;
		r.st = st;
		r.kind = kind;
		r.value = value;
		r.mark = mark;
		r.last = 1'b0;
		rec_q.push_back(r);
	endfunction

	// frame check at one start: returns a status code
	function automatic logic [2:0] frame_status(int unsigned base, int unsigned avail);
		int unsigned len, total;
		logic [7:0] sum;
		sum = '0;
		if (avail < 4) return ST_INCOMPLETE;
		len = rx_buf[base + 1];
		if (rx_buf[base] != START_BYTE || len != rx_buf[base + 2] ||
				rx_buf[base + 3] != START_BYTE)
			return ST_MALFORMED;
		total = len + 6;
		if (avail < total) return ST_INCOMPLETE;
		if (rx_buf[base + total - 1] != STOP_BYTE) return ST_BAD_STOP;
		for (int unsigned i = 4; i < total - 2; i++) sum += rx_buf[base + i];
		if (sum != rx_buf[base + total - 2]) return ST_CHECKSUM;
		if (len < 3) return ST_SHORT_HDR;
		if (rx_buf[base + 6] != CI_BYTE) return ST_BAD_CI;
		if (len < 15) return ST_SHORT_HDR;
		return ST_OK;
	endfunction

	// first match of a record pattern; value must fit before the checksum
	function automatic bit find_record(int unsigned base, int unsigned stop_ofs, int idx,
			output int unsigned pos);
		int unsigned plen, w;
		logic [7:0] pb[3];
		bit eq;
		plen = REC_PAT[idx].plen3 ? 3 : 2;
		w = REC_PAT[idx].wide ? 4 : 2;
		pb[0] = REC_PAT[idx].b0;
		pb[1] = REC_PAT[idx].b1;
		pb[2] = REC_PAT[idx].b2;
		pos = 0;
		for (int unsigned p = REC_FIRST_OFS; p + plen <= stop_ofs; p++) begin
			eq = 1;
			for (int unsigned k = 0; k < plen; k++)
				if (rx_buf[base + p + k] != pb[k]) eq = 0;
			if (eq) begin
				if (p + plen + w > stop_ofs) return 0;
				pos = base + p + plen;
				return 1;
			end
		end
		return 0;
	endfunction

	function automatic void decode_frame(int unsigned base);
		int unsigned stop_ofs, pos;
		logic [31:0] code;
		stop_ofs = rx_buf[base + 1] + 4;
		push_rec(ST_OK, K_SERIAL, read_le(base + 7, 4), 0);
		push_rec(ST_OK, K_MANUF, read_le(base + 11, 2), 0);
		push_rec(ST_OK, K_VERSION, 32'(rx_buf[base + 13]), 0);
		if (find_record(base, stop_ofs, 0, pos))
			push_rec(ST_OK, K_REC0, read_le(pos, 4), 0);
		if (find_record(base, stop_ofs, REC_EC, pos)) begin
			code = read_le(pos, 4);
			push_rec(ST_OK, K_ERRCODE, code, 0);
			if (code == 0)
				push_rec(ST_OK, K_ERRSTRT, '0, 1);
			else if (find_record(base, stop_ofs, REC_ES, pos))
				push_rec(ST_OK, K_ERRSTRT, read_le(pos, 4), 0);
		end
		for (int idx = REC_ES + 1; idx < NUM_REC; idx++)
			if (find_record(base, stop_ofs, idx, pos))
				push_rec(ST_OK, K_REC0 + 4'(idx),
					read_le(pos, REC_PAT[idx].wide ? 4 : 2), 0);
	endfunction

	// one received byte: append, scan every start, decode or trim
	function automatic void absorb_byte(logic [7:0] b);
		int unsigned keep;
		logic [2:0] err, st;
		err = ST_INCOMPLETE;
		if (rx_fill == BUF_BYTES) begin
			for (int unsigned i = 0; i + 1 < BUF_BYTES; i++) rx_buf[i] = rx_buf[i + 1];
			rx_fill--;
		end
		rx_buf[rx_fill] = b;
		rx_fill++;
		keep = rx_fill;
		for (int unsigned i = 0; i < rx_fill; i++) begin
			if (rx_buf[i] == START_BYTE) begin
				st = frame_status(i, rx_fill - i);
				if (st == ST_OK) begin
					decode_frame(i);
					rec_q[rec_q.size() - 1].last = 1'b1;
					rx_fill = 0;
					return;
				end
				if (st == ST_INCOMPLETE) begin
					if (i < keep) keep = i;
				end else begin
					err = st;
				end
			end
		end
		if (keep != 0) begin
			for (int unsigned i = 0; i + keep < rx_fill; i++) rx_buf[i] = rx_buf[i + keep];
			rx_fill -= keep;
		end
		push_rec(err, '0, '0, 0);
		rec_q[rec_q.size() - 1].last = 1'b1;
	endfunction

	// sample both channels at the edge
	always @(posedge clk or negedge arst_n) begin
		rec_item_t e;
		if (!arst_n) begin
			rx_fill <= 0;
			fail_count <= 0;
		end else begin
			if (in_valid && !in_stall) absorb_byte(rx_byte);
			if (out_valid && !out_stall) begin
				if (rec_q.size() == 0) begin
					$error("result item with nothing expected");
					fail_count <= fail_count + 1;
				end else begin
					e = rec_q.pop_front();
					if (status !== e.st ||
							record_kind !== e.kind ||
							record_value !== e.value ||
							no_error_mark !== e.mark ||
							last_result !== e.last)
						fail_count <= fail_count + 1;
					if (status !== e.st)
						$error("status: expected %0d, got %0d", e.st, status);
					if (record_kind !== e.kind)
						$error("record_kind: expected %0d, got %0d", e.kind, record_kind);
					if (record_value !== e.value)
						$error("record_value: expected %h, got %h", e.value, record_value);
					if (no_error_mark !== e.mark)
						$error("no_error_mark: expected %0d, got %0d", e.mark, no_error_mark);
					if (last_result !== e.last)
						$error("last_result: expected %0d, got %0d", e.last, last_result);
				end
			end
		end
	end

endmodule

// ===== test/mbus_long_frame_receiver_tb.sv =====
module mbus_long_frame_receiver_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import mlfr_pkg::*;

	localparam int CYCLE_LIMIT = 3000000;
	localparam int RANDOM_ITEMS = 60;

	typedef enum {FR_GOOD, FR_BAD_SUM, FR_BAD_STOP, FR_BAD_CI, FR_BAD_LEN, FR_SHORT} fault_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  rx_byte;
	logic        out_valid;
	logic        out_stall;
	logic [2:0]  status;
	logic [3:0]  record_kind;
	logic [31:0] record_value;
	logic        no_error_mark;
	logic        last_result;
	int          fail_count;
	int          pending;
	int          cycles;
	int          sent;
	bit          calm;

	mbus_long_frame_receiver DUT (.*);

	mlfr_checker #(.BUF_BYTES(DEF_BUFFER_BYTES)) u_checker (.*);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// receiver stalls, none during the calm stretch
	always @(posedge clk) begin
		out_stall <= calm ? 1'b0 : ($urandom_range(99) < 18);
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// one byte item, with random idle cycles ahead of it
	task automatic send_byte(logic [7:0] b);
		calm = (sent > 30 && sent < 70);
		while (!calm && $urandom_range(99) < 18) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sent++;
	endtask

	function automatic logic [7:0] rand_byte();
		case ($urandom_range(5))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	// long frame with random records, possibly damaged
	task automatic send_frame(fault_t fault);
		logic [7:0] body[$];
		logic [7:0] frm[$];
		logic [7:0] sum;
		int cut;
		body = {8'h08, rand_byte(), CI_BYTE};
		repeat (12) body.push_back(rand_byte());
		for (int idx = 0; idx < NUM_REC; idx++) begin
			if ($urandom_range(9) < 6) begin
				if ($urandom_range(7) == 0) body.push_back(rand_byte());
				body.push_back(REC_PAT[idx].b0);
				body.push_back(REC_PAT[idx].b1);
				if (REC_PAT[idx].plen3) body.push_back(REC_PAT[idx].b2);
				repeat (REC_PAT[idx].wide ? 4 : 2)
					body.push_back((idx == REC_EC && $urandom_range(1)) ? 8'h00 : rand_byte());
			end
		end
		if (fault == FR_SHORT) begin
			cut = $urandom_range(14, 3);
			while (body.size() > cut) void'(body.pop_back());
		end
		if (fault == FR_BAD_CI) body[2] = CI_BYTE ^ 8'($urandom_range(255, 1));
		sum = '0;
		foreach (body[i]) sum += body[i];
		frm = {START_BYTE, 8'(body.size()), 8'(body.size()), START_BYTE};
		if (fault == FR_BAD_LEN) frm[2] = frm[2] ^ 8'($urandom_range(255, 1));
		frm = {frm, body};
		frm.push_back(fault == FR_BAD_SUM ? sum ^ 8'($urandom_range(255, 1)) : sum);
		frm.push_back(fault == FR_BAD_STOP ? STOP_BYTE ^ 8'($urandom_range(255, 1)) :
			STOP_BYTE);
		foreach (frm[i]) send_byte(frm[i]);
	endtask

	initial begin
		logic [7:0] directed[$];
		int wait_cycles;
		fault_t fault;
		arst_n = 1'b0;
		in_valid = 1'b0;
		rx_byte = '0;
		out_stall = 1'b0;
		cycles = 0;
		sent = 0;
		calm = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero length (short header), both byte extremes, bad CI, malformed start
		directed = {8'h68, 8'h00, 8'h00, 8'h68, 8'h00, 8'h16,
			8'hFF, 8'h00,
			8'h68, 8'h03, 8'h03, 8'h68, 8'h08, 8'h01, 8'h55, 8'h5E, 8'h16,
			8'h68, 8'h01, 8'h02, 8'h68};
		foreach (directed[i]) send_byte(directed[i]);

		// mostly well-formed frames, some damaged, some line noise between them
		while (sent < RANDOM_ITEMS + directed.size()) begin
			repeat ($urandom_range(2)) send_byte(rand_byte());
			case ($urandom_range(11))
				0: fault = FR_BAD_SUM;
				1: fault = FR_BAD_STOP;
				2: fault = FR_BAD_CI;
				3: fault = FR_BAD_LEN;
				4: fault = FR_SHORT;
				default: fault = FR_GOOD;
			endcase
			send_frame(fault);
		end
		calm = 1'b0;
		in_valid <= 1'b0;

		while (pending != 0) @(posedge clk);
		wait_cycles = 0;
		while (wait_cycles < 2000) begin
			@(posedge clk);
			wait_cycles++;
		end
		if (fail_count == 0 && pending == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
